/* hw/rtl/keypad_long_press_detector_macros.svh */
// Assertion macros used by the port-level checker of the keypad long-press detector.
`ifndef KEYPAD_LONG_PRESS_DETECTOR_MACROS_SVH
`define KEYPAD_LONG_PRESS_DETECTOR_MACROS_SVH

// Checked on every rising clock edge once reset has been released.
`define KPLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, including while reset is held.
`define KPLD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/kpld_pkg.sv */
// Shared constants and types for the keypad long-press detector.
package kpld_pkg;

    localparam int NUM_KEYS   = 8;
    localparam int KEYS_W     = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int KEY_SCAN   = (NUM_KEYS < KEYS_W) ? NUM_KEYS : KEYS_W;
    localparam int TDATA_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Event kinds.
    localparam logic [1:0] EV_DOWN  = 2'd0;
    localparam logic [1:0] EV_UP    = 2'd1;
    localparam logic [1:0] EV_PRESS = 2'd2;
    localparam logic [1:0] EV_LONG  = 2'd3;

    // Detector phases; the fourth code behaves as idle.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENABLE = 2'd2;

    localparam logic [7:0] LONG_TICKS_RESET   = 8'd50;
    localparam logic [3:0] EVENT_ENABLE_RESET = 4'hF;

    typedef struct packed {
        logic [1:0]           kind;
        logic [KEY_IDX_W-1:0] key;
        logic                 was_long;
        logic                 last;
    } event_t;

    // Results produced by one processed scan tick.
    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } push_t;

endpackage

/* hw/rtl/kpld_in_stage.sv */
// Input register holding one scan tick until the detector engine takes it.
module kpld_in_stage
    import kpld_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KEYS_W-1:0] s_tdata,
    input  logic              take,
    output logic              item_valid,
    output logic [KEYS_W-1:0] item_keys
);

    logic              valid_reg;
    logic              valid_next;
    logic [KEYS_W-1:0] keys_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            keys_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_keys  = keys_reg;

endmodule

/* hw/rtl/kpld_engine.sv */
// Configuration registers and the press-tracking state machine with its event selection.
module kpld_engine
    import kpld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  take,
    input  logic [KEYS_W-1:0]     keys,
    output push_t                 push
);

    logic                 scan_en_reg;
    logic [7:0]           limit_reg;
    logic [3:0]           ev_en_reg;

    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [KEY_IDX_W-1:0] held_reg;
    logic [KEY_IDX_W-1:0] held_next;
    logic [7:0]           ticks_reg;
    logic [7:0]           ticks_next;

    logic                 level;
    logic                 reached;
    logic                 found;
    logic [KEY_IDX_W-1:0] pick;
    logic                 c0_vld;
    logic [1:0]           c0_kind;
    logic                 c0_long;
    logic                 c1_vld;
    logic [1:0]           c1_kind;
    logic                 c1_long;
    logic                 en0;
    logic                 en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_en_reg <= 1'b0;
            limit_reg   <= LONG_TICKS_RESET;
            ev_en_reg   <= EVENT_ENABLE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SCAN_ENABLE) begin
                scan_en_reg <= cfg_data[0];
            end
            if (cfg_index == REG_LONG_TICKS) begin
                limit_reg <= cfg_data[7:0];
            end
            if (cfg_index == REG_EVENT_ENABLE) begin
                ev_en_reg <= cfg_data[3:0];
            end
        end
    end

    assign level   = keys[held_reg];
    assign reached = (ticks_reg >= limit_reg);

    // Lowest-numbered pressed key among the scanned ones.
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = KEY_SCAN - 1; i >= 0; i--) begin
            if (keys[i]) begin
                found = 1'b1;
                pick  = KEY_IDX_W'(i);
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        ticks_next = ticks_reg;
        c0_vld     = 1'b0;
        c0_kind    = EV_DOWN;
        c0_long    = 1'b0;
        c1_vld     = 1'b0;
        c1_kind    = EV_DOWN;
        c1_long    = 1'b0;
        if (!scan_en_reg) begin
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_COUNT: begin
                    if (reached) begin
                        c0_vld  = 1'b1;
                        c0_kind = EV_LONG;
                        if (level) begin
                            phase_next = PH_WAIT;
                        end else begin
                            c1_vld     = 1'b1;
                            c1_kind    = EV_UP;
                            c1_long    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end else if (level) begin
                        ticks_next = ticks_reg + 8'd1;
                    end else begin
                        c0_vld     = 1'b1;
                        c0_kind    = EV_UP;
                        c1_vld     = 1'b1;
                        c1_kind    = EV_PRESS;
                        phase_next = PH_IDLE;
                    end
                end
                PH_WAIT: begin
                    if (!level) begin
                        c0_vld     = 1'b1;
                        c0_kind    = EV_UP;
                        c0_long    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (found) begin
                        held_next  = pick;
                        phase_next = PH_COUNT;
                        c0_vld     = 1'b1;
                        c0_kind    = EV_DOWN;
                        // The key already reads pressed on this tick, so its first count
                        // step happens now; a zero threshold makes it long at once.
                        if (limit_reg == 8'd0) begin
                            ticks_next = 8'd0;
                            c1_vld     = 1'b1;
                            c1_kind    = EV_LONG;
                            phase_next = PH_WAIT;
                        end else begin
                            ticks_next = 8'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign en0 = c0_vld && ev_en_reg[c0_kind];
    assign en1 = c1_vld && ev_en_reg[c1_kind];

    always_comb begin
        push.count       = {1'b0, en0} + {1'b0, en1};
        push.ev0.kind     = en0 ? c0_kind : c1_kind;
        push.ev0.was_long = en0 ? c0_long : c1_long;
        push.ev0.key      = held_next;
        push.ev0.last     = !(en0 && en1);
        push.ev1.kind     = c1_kind;
        push.ev1.was_long = c1_long;
        push.ev1.key      = held_next;
        push.ev1.last     = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
            ticks_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

/* hw/rtl/kpld_out_buf.sv */
// Two-entry result register that feeds the result stream one event at a time.
module kpld_out_buf
    import kpld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_en,
    input  push_t              push,
    output logic               can_take,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    event_t     slot0_reg;
    event_t     slot0_next;
    event_t     slot1_reg;
    event_t     slot1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop      = (count_reg != 2'd0) && m_tready;
    assign can_take = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push_en) begin
            slot0_next = push.ev0;
            slot1_next = push.ev1;
            count_next = push.count;
        end else if (pop) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {2'b00, slot0_reg.was_long, slot0_reg.key, slot0_reg.kind};
    assign m_tlast  = slot0_reg.last;

endmodule

/* hw/rtl/keypad_long_press_detector.sv */
// Keypad long-press detector: top level joining input register, engine and result buffer.
//
// Each slave-side transaction is one scan tick whose tdata is the mask of keys that
// read pressed. From an idle phase the lowest-numbered pressed key is taken, key down
// is reported and its held ticks are counted. A release before the threshold gives
// key up (short) and short press; reaching the threshold gives long press and, at
// release, key up (long). Event kinds with a clear enable bit are not reported.
// A tick yields zero, one or two master-side transactions; tlast marks the final
// event of a tick.
// A tick accepted into the input register is taken by the engine once the result
// buffer can accept its events, which are registered there before they are shown.
// Throughput is one tick per cycle while every tick yields at most one event and the
// receiver is ready; after a two-event tick the next waits until the first is taken.
// When the receiver stalls, results wait in the two-entry buffer and one further
// tick waits in the input register; after that s_tready drops.
// Configuration writes are always taken (cfg_ready is high) and are meant to be
// issued only while no tick is in flight. Reset clears the phase to idle, the
// buffers to empty and loads scan_enable 0, long_press_ticks 50, event_enable 15.
module keypad_long_press_detector
    import kpld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Scan tick channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEYS_W-1:0]     s_tdata,   // [7:0] keys_pressed
    // Event channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [1:0] event_kind, [4:2] key_index,
                                             // [5] was_long, [7:6] zero
    output logic                  m_tlast,   // last_event
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              item_valid;
    logic [KEYS_W-1:0] item_keys;
    logic              can_take;
    logic              take;
    push_t             push;

    assign cfg_ready = 1'b1;

    // The engine consumes a held tick only when the result buffer will be empty.
    assign take = item_valid && can_take;

    kpld_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item_keys  (item_keys)
    );

    kpld_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .keys      (item_keys),
        .push      (push)
    );

    kpld_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (take),
        .push     (push),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/kpld_checker.sv */
// Port-level checker for the keypad long-press detector and its bind statement.
`include "keypad_long_press_detector_macros.svh"

module kpld_checker
    import kpld_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    `KPLD_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "event dropped while stalled")
    `KPLD_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "event changed while stalled")
    `KPLD_ASSERT(a_press_last, m_tvalid && m_tdata[1:0] == EV_PRESS |-> m_tlast, "short press not final event of its tick")
    `KPLD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "event shown right after reset")

endmodule

bind keypad_long_press_detector kpld_checker u_kpld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* dv/keypad_long_press_detector_test.sv */
// Self-checking testbench for the keypad long-press detector.
`timescale 1ns / 1ps

module keypad_long_press_detector_test;
    import kpld_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int TICK_TARGET   = 1450;
    // A tick with no event can still sit in the input register and the engine
    // after the last expected event has been taken, so a quiet block is only
    // assumed after a further settling wait.
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {
        SINK_READY,
        SINK_COIN,
        SINK_SPARSE,
        SINK_HELD
    } sink_mode_t;

    // Tracks the detector's phase, held key and tick count, and keeps the
    // events that the accepted scan ticks still owe.
    class key_event_tracker;
        logic                 scan_on;
        logic [7:0]           long_ticks;
        logic [3:0]           report_mask;
        logic [1:0]           stage;
        logic [KEY_IDX_W-1:0] held;
        logic [7:0]           held_ticks;
        event_t               tick_events[$];
        event_t               pending_events[$];
        int unsigned          mismatches;

        function new();
            scan_on     = 1'b0;
            long_ticks  = LONG_TICKS_RESET;
            report_mask = EVENT_ENABLE_RESET;
            stage       = PH_IDLE;
            held        = '0;
            held_ticks  = '0;
            mismatches  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_SCAN_ENABLE:  scan_on = value[0];
                REG_LONG_TICKS:   long_ticks = value;
                REG_EVENT_ENABLE: report_mask = value[3:0];
                default: ;
            endcase
        endfunction

        // Masked kinds are dropped, and a tick never yields more than two events.
        function void report(logic [1:0] kind, logic was_long);
            event_t ev;
            if (!report_mask[kind] || tick_events.size() >= 2)
                return;
            ev.kind     = kind;
            ev.key      = held;
            ev.was_long = was_long;
            ev.last     = 1'b0;
            tick_events.push_back(ev);
        endfunction

        function void advance_count(logic level);
            if (held_ticks >= long_ticks) begin
                report(EV_LONG, 1'b0);
                if (level) begin
                    stage = PH_WAIT;
                end else begin
                    report(EV_UP, 1'b1);
                    stage = PH_IDLE;
                end
            end else if (level) begin
                held_ticks = held_ticks + 8'd1;
            end else begin
                report(EV_UP, 1'b0);
                report(EV_PRESS, 1'b0);
                stage = PH_IDLE;
            end
        endfunction

        function void note_tick(logic [KEYS_W-1:0] keys);
            event_t ev;
            tick_events.delete();
            if (!scan_on) begin
                stage = PH_IDLE;
                return;
            end
            case (stage)
                PH_COUNT: advance_count(keys[held]);
                PH_WAIT: begin
                    if (!keys[held]) begin
                        report(EV_UP, 1'b1);
                        stage = PH_IDLE;
                    end
                end
                default: begin
                    stage = PH_IDLE;
                    for (int i = 0; i < KEY_SCAN; i++) begin
                        if (keys[i]) begin
                            held       = KEY_IDX_W'(i);
                            held_ticks = '0;
                            stage      = PH_COUNT;
                            report(EV_DOWN, 1'b0);
                            advance_count(1'b1);
                            break;
                        end
                    end
                end
            endcase
            foreach (tick_events[i]) begin
                ev      = tick_events[i];
                ev.last = (i == tick_events.size() - 1);
                pending_events.push_back(ev);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(logic [TDATA_W-1:0] tdata, logic tlast);
            event_t want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual tdata %h tlast %b",
                         $time, tdata, tlast);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", want.kind, tdata[1:0]);
            compare_field("key_index", want.key, tdata[4:2]);
            compare_field("was_long", want.was_long, tdata[5]);
            compare_field("tdata padding", 0, tdata[7:6]);
            compare_field("last_event", want.last, tlast);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [KEYS_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SCAN_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    key_event_tracker tracker = new();

    int         burst_left  = 0;
    int         scan_ticks  = 0;
    int         cycle_count = 0;
    sink_mode_t sink_mode   = SINK_READY;
    int         sink_left   = 0;

    keypad_long_press_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Guards against a hung handshake or events that never arrive.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Event side: every accepted transaction is checked against the oldest
    // expectation, then tready follows a stall pattern of its own that changes
    // mode now and then, from always ready down to being held off entirely.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_event(m_tdata, m_tlast);
        if (sink_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = (sink_mode == SINK_HELD) ? $urandom_range(1, 16)
                                                 : $urandom_range(8, 64);
        end else begin
            sink_left--;
        end
        case (sink_mode)
            SINK_READY:  m_tready <= 1'b1;
            SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= 1'b0;
        endcase
    end

    // Sends one scan tick. The sender runs in bursts; between bursts tvalid
    // drops for a random gap (sometimes none). tvalid is never lowered right
    // after an acceptance, so a back-to-back tick never sees two assignments
    // to tvalid in one time step. The tick is handed to the tracker at the
    // edge where it is taken.
    task automatic send_tick(input logic [KEYS_W-1:0] keys);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= keys;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        burst_left--;
        if (tracker.scan_on)
            scan_ticks++;
        tracker.note_tick(keys);
    endtask

    // cfg_valid stays high across consecutive writes; callers lower it once done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        tracker.write_register(index, value);
    endtask

    task automatic configure(input logic scan, input logic [7:0] ticks,
                             input logic [3:0] mask);
        write_reg(REG_SCAN_ENABLE, CFG_DATA_W'(scan));
        write_reg(REG_LONG_TICKS, ticks);
        write_reg(REG_EVENT_ENABLE, CFG_DATA_W'(mask));
        cfg_valid <= 1'b0;
    endtask

    // Stops sending, waits for every owed event and lets in-flight ticks settle,
    // so that registers may be written afterwards.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One well-formed press: a tick whose lowest pressed key is the chosen one,
    // then hold ticks that keep it pressed while other keys chatter, then a
    // release tick on which other keys may still read pressed.
    task automatic key_press(input int hold);
        int                key;
        logic [KEYS_W-1:0] keys;
        key  = $urandom_range(0, KEY_SCAN - 1);
        keys = KEYS_W'($urandom());
        keys = keys & ~((KEYS_W'(1) << key) - KEYS_W'(1));
        keys[key] = 1'b1;
        send_tick(keys);
        repeat (hold) begin
            keys      = KEYS_W'($urandom());
            keys[key] = 1'b1;
            send_tick(keys);
        end
        keys      = KEYS_W'($urandom());
        keys[key] = 1'b0;
        send_tick(keys);
    endtask

    // Hold lengths cluster around the threshold so that releases land just
    // before, on and just after the tick where a press turns long. Large
    // thresholds keep to short holds; each such phase forces one long hold.
    function automatic int hold_length(int thr);
        int pick;
        pick = $urandom_range(0, 3);
        if (thr > 40 && (pick == 1 || pick == 2))
            pick = 0;
        case (pick)
            0:       return $urandom_range(0, 3);
            1:       return (thr >= 2) ? thr - 2 + $urandom_range(0, 2) : $urandom_range(0, 1);
            2:       return thr + $urandom_range(0, 4);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    initial begin
        int         phase_no;
        int         budget;
        logic [7:0] thr;
        logic [3:0] mask;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Scanning is off after reset, so these ticks must yield nothing.
        send_tick(8'hFF);
        send_tick(8'h01);
        wait_idle();

        // Turn scanning on alone: threshold 50 and all events from reset.
        // Key 0 is picked out of a full mask, held once and released short;
        // then key 7 is released while every other key reads pressed.
        write_reg(REG_SCAN_ENABLE, CFG_DATA_W'(1));
        cfg_valid <= 1'b0;
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h01);
        send_tick(8'h00);
        send_tick(8'h80);
        send_tick(8'h7F);
        wait_idle();

        // Threshold 1: a press turns long on the tick after key down. Key 2
        // waits for release in the long phase; key 4 is released on the very
        // tick that reports long press, so key up (long) follows at once.
        configure(1'b1, 8'd1, 4'hF);
        send_tick(8'h04);
        send_tick(8'h04);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'h10);
        send_tick(8'h00);
        wait_idle();

        // Only key down and short press reported; masked events still move
        // the state along, including a silent long press and key up.
        configure(1'b1, 8'd2, 4'b0101);
        send_tick(8'h02);
        send_tick(8'h00);
        send_tick(8'h40);
        send_tick(8'h40);
        send_tick(8'h40);
        send_tick(8'h00);
        wait_idle();

        // Only key up and long press reported.
        configure(1'b1, 8'd1, 4'b1010);
        send_tick(8'h08);
        send_tick(8'h00);
        wait_idle();

        // Threshold lowered under a press in progress: the count already
        // reached counts as long on the next tick.
        configure(1'b1, 8'd255, 4'hF);
        send_tick(8'h20);
        send_tick(8'h20);
        wait_idle();
        configure(1'b1, 8'd1, 4'hF);
        send_tick(8'h20);
        send_tick(8'h00);
        wait_idle();

        // Scanning switched off under a press: it is dropped silently and a
        // fresh key down follows once scanning is back.
        configure(1'b1, 8'd255, 4'hF);
        send_tick(8'h01);
        wait_idle();
        configure(1'b0, 8'd255, 4'hF);
        send_tick(8'h01);
        wait_idle();
        configure(1'b1, 8'd255, 4'hF);
        send_tick(8'h03);
        send_tick(8'h00);
        wait_idle();

        // Random phases, each under its own register setting. The first ones
        // hit the extremes: the longest threshold with one full long press,
        // the shortest with every event masked, and with every event shown.
        phase_no = 0;
        while (scan_ticks < TICK_TARGET) begin
            case (phase_no)
                0: begin
                    thr  = 8'd255;
                    mask = 4'hF;
                end
                1: begin
                    thr  = 8'd1;
                    mask = 4'h0;
                end
                2: begin
                    thr  = 8'd1;
                    mask = 4'hF;
                end
                default: begin
                    thr  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(9, 30))
                                                       : 8'($urandom_range(1, 8));
                    mask = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
                end
            endcase

            // Now and then a stretch with scanning off; those ticks are ignored.
            if (phase_no % 5 == 4) begin
                configure(1'b0, thr, mask);
                repeat ($urandom_range(4, 8)) send_tick(KEYS_W'($urandom()));
                wait_idle();
            end

            configure(1'b1, thr, mask);
            if (phase_no == 0)
                key_press(256);
            budget = scan_ticks + ((phase_no == 1) ? 40 : $urandom_range(60, 140));
            while (scan_ticks < budget && scan_ticks < TICK_TARGET) begin
                if ($urandom_range(0, 4) == 0) begin
                    // Noise: arbitrary masks that break sequences anywhere.
                    repeat ($urandom_range(1, 6)) send_tick(KEYS_W'($urandom()));
                end else begin
                    repeat ($urandom_range(0, 2)) send_tick('0);
                    key_press(hold_length(thr));
                end
            end
            wait_idle();
            phase_no++;
        end

        wait_idle();
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
